// File: rtl/arcr_pkg.sv
// Shared types, opcode masks and result codes for the ARM relocation rewriter.
package arcr_pkg;

    localparam int POOL_BYTES_DEF = 64;

    // Instruction class masks and patterns
    localparam logic [31:0] MASK_OP      = 32'h0F00_0000;
    localparam logic [31:0] PAT_BL       = 32'h0B00_0000;
    localparam logic [31:0] PAT_B        = 32'h0A00_0000;
    localparam logic [31:0] MASK_DP_ADD  = 32'h0DE0_0000;
    localparam logic [31:0] PAT_DP_ADD   = 32'h0080_0000;
    localparam logic [31:0] MASK_LDST    = 32'h0C00_0000;
    localparam logic [31:0] PAT_LDST     = 32'h0400_0000;
    localparam logic [31:0] MASK_ADR_KEEP = 32'hF000_F000;
    localparam logic [31:0] PAT_LDR_PC   = 32'h051F_0000;
    localparam logic [31:0] MASK_LDR_KEEP = 32'hFF7F_F000;
    localparam logic [31:0] BR_FWD_LIMIT = 32'h0080_0000;
    localparam logic [31:0] BR_BWD_LIMIT = 32'hFF80_0000;
    localparam logic [31:0] UP_BIT       = 32'h0080_0000;
    localparam logic [3:0]  REG_PC       = 4'hF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_IMAGE_BASE   = 2'd0,
        CFG_REGION_START = 2'd1,
        CFG_REGION_END   = 2'd2,
        CFG_TARGET_BASE  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_CODE = 2'd0,
        KIND_LIT  = 2'd1,
        KIND_COPY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BR_RANGE  = 2'd1,
        ST_ADD_MODE  = 2'd2,
        ST_POOL_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] image_base;
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic [31:0] target_base;
    } cfg_t;

    typedef struct packed {
        logic [31:0] source_pc;
        logic [31:0] target_pc;
        logic [31:0] pool_pointer;
    } state_t;

    // Results caused by one instruction: optional pool write, then code word
    typedef struct packed {
        logic        pool_valid;
        kind_t       pool_kind;
        logic [31:0] pool_addr;
        logic [31:0] pool_word;
        logic [31:0] copy_offset;
        logic [31:0] code_addr;
        logic [31:0] code_word;
        status_t     status;
    } pair_t;

endpackage

// File: rtl/arm_code_relocation_rewriter_core.sv
// Top level: config registers, input register, stream state and result stage.
// An accepted request is held in the input register, then loaded into the result register.
// Throughput: one instruction per cycle while the output does not stall; one that writes
// a pool slot holds the result port while the single result register drains its pair.
// Reset: config registers clear to zero; source pc to 0, target pc to POOL_BYTES,
// pool pointer to 0; input and result registers empty.
module arm_code_relocation_rewriter_core #(
    parameter int POOL_BYTES = arcr_pkg::POOL_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instr_word,
    input  logic        first_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  write_kind,
    output logic [31:0] write_addr,
    output logic [31:0] write_word,
    output logic [31:0] copy_offset,
    output logic [1:0]  status,
    output logic        last_of_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    arcr_pkg::cfg_t   cfg_reg;
    arcr_pkg::state_t state_reg, state_next;
    arcr_pkg::pair_t  pair;
    logic             in_valid_reg;
    logic [31:0]      word_reg;
    logic             first_reg;
    logic             load_ok, advance, in_take;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (arcr_pkg::cfg_index_t'(cfg_index))
                arcr_pkg::CFG_IMAGE_BASE:   cfg_reg.image_base   <= cfg_data;
                arcr_pkg::CFG_REGION_START: cfg_reg.region_start <= cfg_data;
                arcr_pkg::CFG_REGION_END:   cfg_reg.region_end   <= cfg_data;
                arcr_pkg::CFG_TARGET_BASE:  cfg_reg.target_base  <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: advance into the result stage when it has room
    assign advance  = in_valid_reg && load_ok;
    assign in_stall = in_valid_reg && !load_ok;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg  <= instr_word;
            first_reg <= first_word;
        end
    end

    arcr_decode #(
        .POOL_BYTES (POOL_BYTES)
    ) u_decode (
        .word  (word_reg),
        .first (first_reg),
        .cfg   (cfg_reg),
        .cur   (state_reg),
        .pair  (pair),
        .nxt   (state_next)
    );

    // Stream state moves with each instruction handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.source_pc    <= 32'd0;
            state_reg.target_pc    <= 32'(POOL_BYTES);
            state_reg.pool_pointer <= 32'd0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    arcr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .pair_in      (pair),
        .load_ok      (load_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_kind   (write_kind),
        .write_addr   (write_addr),
        .write_word   (write_word),
        .copy_offset  (copy_offset),
        .status       (status),
        .last_of_item (last_of_item)
    );

endmodule

// File: rtl/arcr_decode.sv
// Decode and rewrite of one instruction word, with next pc and pool state.
module arcr_decode #(
    parameter int POOL_BYTES = arcr_pkg::POOL_BYTES_DEF
) (
    input  logic [31:0]      word,
    input  logic             first,
    input  arcr_pkg::cfg_t   cfg,
    input  arcr_pkg::state_t cur,
    output arcr_pkg::pair_t  pair,
    output arcr_pkg::state_t nxt
);

    localparam logic [31:0] POOL_W     = 32'(POOL_BYTES);
    localparam logic [31:0] POOL_LIMIT = 32'(POOL_BYTES - 4);

    logic [31:0] pc, tpc, pp;
    logic        is_br, is_add, is_ldst;
    logic [31:0] off4, br_dest, br_diff, br_q;
    logic        br_ok;
    logic [63:0] rot_dbl, rot_res;
    logic [4:0]  rot_amt;
    logic [31:0] add_dest;
    logic [31:0] imm12, ldr_dest, copy_ofs;
    logic [31:0] dest;
    logic        in_region, pool_full;
    logic [31:0] pd, pd_neg, ofs_bits;

    // Restart the stream state on the first word
    always_comb
    begin
        if (first)
        begin
            pc  = cfg.region_start;
            tpc = cfg.target_base + POOL_W;
            pp  = cfg.target_base;
        end
        else
        begin
            pc  = cur.source_pc;
            tpc = cur.target_pc;
            pp  = cur.pool_pointer;
        end
    end

    // Classify the word
    assign is_br   = ((word & arcr_pkg::MASK_OP) == arcr_pkg::PAT_BL) ||
                     ((word & arcr_pkg::MASK_OP) == arcr_pkg::PAT_B);
    assign is_add  = (word & arcr_pkg::MASK_DP_ADD) == arcr_pkg::PAT_DP_ADD;
    assign is_ldst = (word & arcr_pkg::MASK_LDST) == arcr_pkg::PAT_LDST;

    // Branch target and new offset, computed side by side
    assign off4    = {{6{word[23]}}, word[23:0], 2'b00};
    assign br_dest = pc + off4 + 32'd8;
    assign br_diff = pc + off4 - tpc;
    assign br_q    = {{2{br_diff[31]}}, br_diff[31:2]};
    assign br_ok   = (br_q < arcr_pkg::BR_FWD_LIMIT) || (br_q > arcr_pkg::BR_BWD_LIMIT);

    // ADR immediate as a true 32-bit rotate right
    assign rot_amt  = {word[11:8], 1'b0};
    assign rot_dbl  = {24'd0, word[7:0], 24'd0, word[7:0]};
    assign rot_res  = rot_dbl >> rot_amt;
    assign add_dest = pc + 32'd8 + rot_res[31:0];

    // Pc-relative load target and its offset in the source buffer
    assign imm12    = {20'd0, word[11:0]};
    assign ldr_dest = word[23] ? (pc + 32'd8 + imm12) : (pc + 32'd8 - imm12);
    assign copy_ofs = ldr_dest - cfg.image_base;

    // Pick the target that matters for this class
    always_comb
    begin
        priority if (is_br)
            dest = br_dest;
        else if (is_add)
            dest = add_dest;
        else
            dest = ldr_dest;
    end

    assign in_region = (cfg.region_start <= dest) && (dest < cfg.region_end);
    assign pool_full = (pp - cfg.target_base) > POOL_LIMIT;

    // Offset field that reaches the pool slot from the new code word
    assign pd       = pp - tpc - 32'd8;
    assign pd_neg   = 32'd0 - pd;
    assign ofs_bits = pd[31] ? {20'd0, pd_neg[11:0]}
                             : (arcr_pkg::UP_BIT | {20'd0, pd[11:0]});

    // Rewrite and advance both pcs by one word
    always_comb
    begin
        pair.pool_valid  = 1'b0;
        pair.pool_kind   = arcr_pkg::KIND_LIT;
        pair.pool_addr   = pp;
        pair.pool_word   = 32'd0;
        pair.copy_offset = 32'd0;
        pair.code_addr   = tpc;
        pair.code_word   = word;
        pair.status      = arcr_pkg::ST_OK;
        nxt.source_pc    = pc + 32'd4;
        nxt.target_pc    = tpc + 32'd4;
        nxt.pool_pointer = pp;

        priority if (is_br)
        begin
            if (!in_region)
            begin
                if (br_ok)
                    pair.code_word = {word[31:24], br_q[23:0]};
                else
                    pair.status = arcr_pkg::ST_BR_RANGE;
            end
        end
        else if (is_add)
        begin
            if (word[19:16] == arcr_pkg::REG_PC && word[15:12] != arcr_pkg::REG_PC)
            begin
                if (!word[25])
                    pair.status = arcr_pkg::ST_ADD_MODE;
                else if (!in_region)
                begin
                    if (pool_full)
                        pair.status = arcr_pkg::ST_POOL_FULL;
                    else
                    begin
                        pair.code_word = (word & arcr_pkg::MASK_ADR_KEEP) |
                                         arcr_pkg::PAT_LDR_PC | ofs_bits;
                        pair.pool_valid  = 1'b1;
                        pair.pool_kind   = arcr_pkg::KIND_LIT;
                        pair.pool_word   = add_dest;
                        nxt.pool_pointer = pp + 32'd4;
                    end
                end
            end
        end
        else if (is_ldst)
        begin
            if (word[19:16] == arcr_pkg::REG_PC && !in_region)
            begin
                if (pool_full)
                    pair.status = arcr_pkg::ST_POOL_FULL;
                else
                begin
                    pair.code_word   = (word & arcr_pkg::MASK_LDR_KEEP) | ofs_bits;
                    pair.pool_valid  = 1'b1;
                    pair.pool_kind   = arcr_pkg::KIND_COPY;
                    pair.copy_offset = copy_ofs;
                    nxt.pool_pointer = pp + 32'd4;
                end
            end
        end
        else
        begin
            // Copy any other word unchanged
        end
    end

endmodule

// File: rtl/arcr_out.sv
// Result register that sends the pool write, if any, and then the code word.
module arcr_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  arcr_pkg::pair_t pair_in,
    output logic            load_ok,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      write_kind,
    output logic [31:0]     write_addr,
    output logic [31:0]     write_word,
    output logic [31:0]     copy_offset,
    output logic [1:0]      status,
    output logic            last_of_item
);

    arcr_pkg::pair_t pair_reg;
    logic            valid_reg, valid_next;
    logic            phase_reg, phase_next;
    logic            take, done, show_pool;

    assign show_pool = pair_reg.pool_valid && !phase_reg;
    assign take      = valid_reg && !out_stall;
    assign done      = take && !show_pool;
    assign load_ok   = !valid_reg || done;

    // Track which result of the pair goes next
    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (done)
            valid_next = 1'b0;
        else if (take)
            phase_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Hold the pair payload
    always_ff @(posedge clk)
    begin
        if (load)
            pair_reg <= pair_in;
    end

    // Drive the current result
    assign out_valid = valid_reg;
    always_comb
    begin
        if (show_pool)
        begin
            write_kind   = pair_reg.pool_kind;
            write_addr   = pair_reg.pool_addr;
            write_word   = pair_reg.pool_word;
            copy_offset  = pair_reg.copy_offset;
            status       = arcr_pkg::ST_OK;
            last_of_item = 1'b0;
        end
        else
        begin
            write_kind   = arcr_pkg::KIND_CODE;
            write_addr   = pair_reg.code_addr;
            write_word   = pair_reg.code_word;
            copy_offset  = 32'd0;
            status       = pair_reg.status;
            last_of_item = 1'b1;
        end
    end

endmodule

// File: tb/sv/arm_code_relocation_rewriter_core_test.sv
// Self-checking testbench for the ARM code relocation rewriter core.
import arcr_pkg::*;

typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] word;
    logic [31:0] coff;
    status_t     st;
    logic        last;
} write_rec_t;

// Predicts the relocated writes and checks each write the core produces
class relocation_scoreboard;
    logic [31:0] image_base, region_start, region_end, target_base;
    logic [31:0] source_pc, target_pc, pool_ptr;
    write_rec_t  pending_writes[$];
    int          mismatches, words_seen, writes_checked;
    int          retargeted, out_of_range, add_mode, literals, copies, overflows, far_pool;

    function new();
        image_base = '0;
        region_start = '0;
        region_end = '0;
        target_base = '0;
        restart();
        mismatches = 0;
        words_seen = 0;
        writes_checked = 0;
        retargeted = 0;
        out_of_range = 0;
        add_mode = 0;
        literals = 0;
        copies = 0;
        overflows = 0;
        far_pool = 0;
    endfunction

    function void restart();
        source_pc = region_start;
        target_pc = target_base + POOL_BYTES_DEF;
        pool_ptr = target_base;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] value);
        case (idx)
            CFG_IMAGE_BASE:   image_base = value;
            CFG_REGION_START: region_start = value;
            CFG_REGION_END:   region_end = value;
            CFG_TARGET_BASE:  target_base = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return pending_writes.size();
    endfunction

    function bit in_region(logic [31:0] a);
        return region_start <= a && a < region_end;
    endfunction

    // Slot offset is taken mod 2^32, so a moved target base can overflow at once
    function bit pool_full();
        return (pool_ptr - target_base) > 32'(POOL_BYTES_DEF - 4);
    endfunction

    // U bit and 12-bit magnitude that reach the current pool slot
    function logic [31:0] pool_offset_bits();
        logic [31:0] d;
        logic [31:0] up;
        d = pool_ptr - target_pc - 32'd8;
        up = UP_BIT;
        if (d[31])
        begin
            up = '0;
            d = -d;
        end
        if (d > 32'hFFF)
            far_pool++;
        return up | {20'd0, d[11:0]};
    endfunction

    function void add_write(kind_t k, logic [31:0] a, logic [31:0] w, logic [31:0] c,
                            status_t s, logic l);
        write_rec_t r;
        r.kind = k;
        r.addr = a;
        r.word = w;
        r.coff = c;
        r.st = s;
        r.last = l;
        pending_writes.push_back(r);
    endfunction

    // Work out the writes caused by one accepted instruction request
    function void note_word(logic [31:0] w, logic first);
        logic [31:0] pc, code, off, dest, diff, q, val, imm;
        logic [4:0]  rot;
        status_t     st;
        words_seen++;
        if (first)
            restart();
        pc = source_pc;
        code = w;
        st = ST_OK;
        if ((w & MASK_OP) == PAT_BL || (w & MASK_OP) == PAT_B)
        begin
            off = {{8{w[23]}}, w[23:0]};
            dest = pc + (off << 2) + 32'd8;
            if (!in_region(dest))
            begin
                diff = dest - target_pc - 32'd8;
                q = $signed(diff) >>> 2;
                if (q < BR_FWD_LIMIT || q > BR_BWD_LIMIT)
                begin
                    code = {w[31:24], q[23:0]};
                    retargeted++;
                end
                else
                begin
                    st = ST_BR_RANGE;
                    out_of_range++;
                end
            end
        end
        else if ((w & MASK_DP_ADD) == PAT_DP_ADD)
        begin
            if (w[19:16] == REG_PC && w[15:12] != REG_PC)
            begin
                if (!w[25])
                begin
                    st = ST_ADD_MODE;
                    add_mode++;
                end
                else
                begin
                    // true 32-bit rotate right of the 8-bit immediate
                    rot = {w[11:8], 1'b0};
                    val = 32'({24'd0, w[7:0], 24'd0, w[7:0]} >> rot);
                    dest = pc + 32'd8 + val;
                    if (!in_region(dest))
                    begin
                        if (pool_full())
                        begin
                            st = ST_POOL_FULL;
                            overflows++;
                        end
                        else
                        begin
                            code = (w & MASK_ADR_KEEP) | PAT_LDR_PC | pool_offset_bits();
                            add_write(KIND_LIT, pool_ptr, dest, '0, ST_OK, 1'b0);
                            pool_ptr += 32'd4;
                            literals++;
                        end
                    end
                end
            end
        end
        else if ((w & MASK_LDST) == PAT_LDST)
        begin
            if (w[19:16] == REG_PC)
            begin
                imm = {20'd0, w[11:0]};
                dest = w[23] ? pc + 32'd8 + imm : pc + 32'd8 - imm;
                if (!in_region(dest))
                begin
                    if (pool_full())
                    begin
                        st = ST_POOL_FULL;
                        overflows++;
                    end
                    else
                    begin
                        code = (w & MASK_LDR_KEEP) | pool_offset_bits();
                        add_write(KIND_COPY, pool_ptr, '0, dest - image_base, ST_OK, 1'b0);
                        pool_ptr += 32'd4;
                        copies++;
                    end
                end
            end
        end
        add_write(KIND_CODE, target_pc, code, '0, st, 1'b1);
        source_pc += 32'd4;
        target_pc += 32'd4;
    endfunction

    task report(string msg);
        if (mismatches < 40)
            $display("MISMATCH %s", msg);
        mismatches++;
    endtask

    // Compare one write from the core with the oldest predicted write
    task check_write(write_rec_t got);
        write_rec_t want;
        writes_checked++;
        if (pending_writes.size() == 0)
        begin
            report($sformatf("write to %h arrived with nothing predicted", got.addr));
            return;
        end
        want = pending_writes.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("write_kind at %h: got %0d want %0d", want.addr, got.kind,
                             want.kind));
        if (got.addr !== want.addr)
            report($sformatf("write_addr: got %h want %h", got.addr, want.addr));
        if (got.word !== want.word)
            report($sformatf("write_word at %h: got %h want %h", want.addr, got.word,
                             want.word));
        if (got.coff !== want.coff)
            report($sformatf("copy_offset at %h: got %h want %h", want.addr, got.coff,
                             want.coff));
        if (got.st !== want.st)
            report($sformatf("status at %h: got %0d want %0d", want.addr, got.st, want.st));
        if (got.last !== want.last)
            report($sformatf("last_of_item at %h: got %b want %b", want.addr, got.last,
                             want.last));
    endtask
endclass

module arm_code_relocation_rewriter_core_test;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    // Instruction encoding fields used to build requests
    localparam logic [2:0] CLS_BRANCH = 3'b101;
    localparam logic [1:0] CLS_DP     = 2'b00;
    localparam logic [1:0] CLS_LDST   = 2'b01;
    localparam logic [3:0] OPC_ADD    = 4'b0100;

    typedef enum {SHAPE_NEAR, SHAPE_FAR, SHAPE_ALIGNED, SHAPE_WIDE, SHAPE_EMPTY} shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] instr_word = '0;
    logic        first_word = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  write_kind;
    logic [31:0] write_addr;
    logic [31:0] write_word;
    logic [31:0] copy_offset;
    logic [1:0]  status;
    logic        last_of_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic        calm = 1'b0;
    logic        hold_on = 1'b0;
    int          hold_count = 0;
    int          cycle_count = 0;
    write_rec_t  observed;

    relocation_scoreboard sb;

    arm_code_relocation_rewriter_core #(
        .POOL_BYTES(POOL_BYTES_DEF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .instr_word(instr_word),
        .first_word(first_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .write_kind(write_kind),
        .write_addr(write_addr),
        .write_word(write_word),
        .copy_offset(copy_offset),
        .status(status),
        .last_of_item(last_of_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check accepted writes, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.kind = kind_t'(write_kind);
            observed.addr = write_addr;
            observed.word = write_word;
            observed.coff = copy_offset;
            observed.st = status_t'(status);
            observed.last = last_of_item;
            sb.check_write(observed);
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_on && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 36);
    end

    // Offer one request, after a random gap unless calm; return once it is accepted
    task automatic send_item(logic [31:0] w, logic first);
        if (!calm)
            while ($urandom_range(99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        instr_word <= w;
        first_word <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(w, first);
    endtask

    // Drop valid and wait until every predicted write has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no extra edge
    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_all(logic [31:0] ib, logic [31:0] rs, logic [31:0] re,
                             logic [31:0] tb);
        settle();
        write_reg(CFG_IMAGE_BASE, ib);
        write_reg(CFG_REGION_START, rs);
        write_reg(CFG_REGION_END, re);
        write_reg(CFG_TARGET_BASE, tb);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(shape_t shape);
        logic [31:0] ib, rs, re, tb;
        rs = $urandom & 32'hFFFF_FFFC;
        re = rs + 4 * $urandom_range(16, 1024);
        ib = $urandom_range(1) ? $urandom : rs - 4 * $urandom_range(4096);
        tb = rs + 4 * $urandom_range(1 << 20);
        case (shape)
            // every leaving branch misses the 24-bit reach
            SHAPE_FAR:     tb = rs ^ 32'h8000_0000;
            // target pc tracks source pc, so branch limits are hit exactly
            SHAPE_ALIGNED: tb = rs - POOL_BYTES_DEF;
            SHAPE_WIDE:
            begin
                rs = '0;
                re = '1;
                ib = '0;
            end
            SHAPE_EMPTY:
            begin
                re = rs - 32'h100;
                ib = '1;
                tb = 32'hFFFF_FFC0;
            end
            default: ;
        endcase
        write_all(ib, rs, re, tb);
    endtask

    // Build an instruction aimed at the region edges from the predicted pc
    function automatic logic [31:0] pick_instr(logic first);
        logic [31:0] pc, dest, off;
        logic [3:0]  cond, rn, rd;
        logic [11:0] field;
        int          roll;
        pc = first ? sb.region_start : sb.source_pc;
        cond = 4'($urandom_range(15));
        roll = $urandom_range(99);
        if (roll < 30)
        begin
            case ($urandom_range(5))
                0: dest = pc + 8 + 4 * ($urandom_range(128) - 64);
                1: dest = sb.region_end + 4 * $urandom_range(16);
                2: dest = sb.region_start - 4 * $urandom_range(1, 16);
                3: dest = sb.region_start + 4 * $urandom_range(64);
                default: dest = pc + 8 + ($urandom << 2);
            endcase
            off = (dest - pc - 32'd8) >> 2;
            if ($urandom_range(7) == 0)
                off = $urandom_range(1) ? 32'h007F_FFFF : 32'h0080_0000;
            return {cond, CLS_BRANCH, 1'($urandom_range(1)), off[23:0]};
        end
        if (roll < 50)
        begin
            rn = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : REG_PC;
            rd = ($urandom_range(9) == 0) ? REG_PC : 4'($urandom_range(14));
            field = $urandom_range(1) ? 12'($urandom_range(255)) : 12'($urandom);
            return {cond, CLS_DP, 1'($urandom_range(7) != 0), OPC_ADD,
                    1'($urandom_range(1)), rn, rd, field};
        end
        if (roll < 75)
        begin
            rn = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : REG_PC;
            field = $urandom_range(1) ? 12'($urandom_range(64)) : 12'($urandom);
            return {cond, CLS_LDST, 6'($urandom), rn, 4'($urandom), field};
        end
        return $urandom;
    endfunction

    // Restarted streams of random length, with a little noise mixed in
    task automatic run_streams(int count);
        int   sent, len, k;
        logic first;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 40);
            for (k = 0; k < len && sent < count; k++)
            begin
                first = (k == 0);
                if ($urandom_range(99) < 8)
                    send_item($urandom, 1'($urandom_range(1)));
                else
                    send_item(pick_instr(first), first);
                sent++;
            end
        end
    endtask

    initial
    begin
        int   p, k;
        logic first;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: empty region, state straight from reset
        send_item(32'hEAFF_FFFE, 1'b0);
        send_item(32'h0000_0000, 1'b0);

        write_all(32'h0000_8000, 32'h0001_0000, 32'h0001_0400, 32'h0002_0000);
        send_item(32'hEA00_0000, 1'b1);   // branch staying inside
        send_item(32'hEB7F_FFFF, 1'b0);   // farthest forward BL, retargeted
        send_item(32'hEA80_0000, 1'b0);   // farthest back, out of range
        send_item(32'hE28F_0FFF, 1'b0);   // ADR with rotate, leaves region
        send_item(32'hE28F_0010, 1'b0);   // ADR inside region
        send_item(32'hE28F_01FF, 1'b0);   // rotate wraps into high bits
        send_item(32'hE28F_F010, 1'b0);   // add into pc, jump table
        send_item(32'hE08F_0001, 1'b0);   // add from pc with register operand
        send_item(32'hE59F_0FFC, 1'b0);   // load up, leaves region
        send_item(32'hE51F_0FFF, 1'b0);   // load down, leaves region
        send_item(32'hE59F_0004, 1'b0);   // load inside region
        send_item(32'hE58F_0FF0, 1'b0);   // store through pc
        send_item(32'hE591_0000, 1'b0);   // load from another base
        send_item(32'hFFFF_FFFF, 1'b0);

        // Move target base under a live stream: pool reads as full
        settle();
        write_reg(CFG_TARGET_BASE, 32'h0003_0000);
        cfg_valid <= 1'b0;
        send_item(32'hE28F_0FFF, 1'b0);
        send_item(32'hE51F_0FFF, 1'b0);

        // Region and target at the top of the address space
        write_all(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFE0);
        send_item(32'h1BFF_FFC0, 1'b1);
        send_item(32'hE51F_0010, 1'b0);
        send_item(32'hE28F_00FF, 1'b0);

        // Random streams; first phase runs without idling, second holds the output
        for (p = 0; p < 5; p++)
        begin
            configure(shape_t'(p));
            calm <= (p == 0);
            if (p == 1)
                hold_on <= 1'b1;
            run_streams(60);
        end
        calm <= 1'b0;

        // One long stream, then reopen the pool far behind the code
        configure(SHAPE_NEAR);
        for (k = 0; k < 590; k++)
        begin
            first = (k == 0);
            send_item(pick_instr(first), first);
        end
        settle();
        write_reg(CFG_TARGET_BASE, sb.pool_ptr);
        cfg_valid <= 1'b0;
        repeat (40) send_item(pick_instr(1'b0), 1'b0);
        settle();

        $display("Covered %0d instruction requests, %0d writes checked, %0d mismatches.",
                 sb.words_seen, sb.writes_checked, sb.mismatches);
        $display("Branches %0d moved, %0d out of reach; add-mode %0d; pool %0d/%0d/%0d/%0d.",
                 sb.retargeted, sb.out_of_range, sb.add_mode, sb.literals, sb.copies,
                 sb.overflows, sb.far_pool);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
